// ===== hw/rtl/stfp_pkg.sv =====
// Package: shared constants and result record of the sync TLV frame parser.
`timescale 1ns / 1ps
package stfp_pkg;

  localparam int unsigned TYPE_BYTES   = 2;
  localparam int unsigned LENGTH_BYTES = 4;
  localparam int unsigned BYTE_BITS    = 8;

  typedef struct packed {
    logic [15:0]          frame_type;
    logic [31:0]          frame_length;
    logic [31:0]          byte_offset;
    logic [BYTE_BITS-1:0] payload_byte;
    logic                 has_byte;
    logic                 frame_end;
  } stfp_result_t;

endpackage

// ===== hw/rtl/sync_tlv_frame_parser_unit.sv =====
// Top level: sync-word TLV frame parser with output register and skid stage.
//
// Input channel: in_valid / in_stall with rx_byte, one stream byte per request.
// Output channel: out_valid / out_stall with the frame fields of a payload
// byte, or an empty-frame marker (has_byte low) for a zero-length frame.
// cfg_we / cfg_wdata write the 16-bit sync word; write it only while idle.
//
// One byte is taken every cycle while in_stall is low. A byte that yields a
// result passes to the output register, or to the skid stage when the
// receiver stalls. Header bytes (sync, type, length) give no result, except
// the last length byte of a zero-length frame. The rate rests on the core
// computing each next state combinationally: shift, one 32-bit increment and compare.
//
// When the receiver stalls, the output register holds its request and the
// next result is caught in the skid stage; in_stall is high while that stage
// is full, from the cycle after it fills until the cycle after the receiver
// takes the held request.
//
// Reset (rst, synchronous) clears the sync word to zero, returns the parser
// to hunting with an all-zero window, and empties both output stages.
`timescale 1ns / 1ps
module sync_tlv_frame_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] frame_type,
  output logic [31:0] frame_length,
  output logic [31:0] byte_offset,
  output logic [7:0]  payload_byte,
  output logic        has_byte,
  output logic        frame_end
);
  import stfp_pkg::*;

  logic         accept;
  logic         res_valid;
  stfp_result_t res;
  logic [15:0]  sync_pattern;
  stfp_result_t out_res;
  stfp_result_t skid_res;
  logic         skid_valid;
  logic         out_take;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_take = out_valid && !out_stall;

  stfp_parse_core u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .rx_byte      (rx_byte),
    .sync_pattern (sync_pattern),
    .res_valid    (res_valid),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_pattern <= '0;
    end else if (cfg_we) begin
      sync_pattern <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        // no new request while the skid stage is full
        if (out_take) begin
          out_res    <= skid_res;
          skid_valid <= 1'b0;
        end
      end else if (out_valid && out_stall) begin
        if (res_valid) begin
          skid_res   <= res;
          skid_valid <= 1'b1;
        end
      end else begin
        out_valid <= res_valid;
        if (res_valid) begin
          out_res <= res;
        end
      end
    end
  end

  assign frame_type   = out_res.frame_type;
  assign frame_length = out_res.frame_length;
  assign byte_offset  = out_res.byte_offset;
  assign payload_byte = out_res.payload_byte;
  assign has_byte     = out_res.has_byte;
  assign frame_end    = out_res.frame_end;

endmodule

// ===== hw/rtl/stfp_parse_core.sv =====
// Parser core: hunt / type / length / payload state and per-byte result.
`timescale 1ns / 1ps
module stfp_parse_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [7:0]                 rx_byte,
  input  logic [15:0]                sync_pattern,
  output logic                       res_valid,
  output stfp_pkg::stfp_result_t     res
);
  import stfp_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_TYPE    = 2'd1,
    PH_LENGTH  = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] sync_window, sync_window_next;
  logic [31:0] field_count, field_count_next;
  logic [15:0] type_accum, type_accum_next;
  logic [31:0] length_accum, length_accum_next;
  logic [31:0] count_inc;
  logic [15:0] window_shift;
  logic [31:0] length_shift;

  assign count_inc    = field_count + 32'd1;
  assign window_shift = {sync_window[15-BYTE_BITS:0], rx_byte};
  assign length_shift = {length_accum[31-BYTE_BITS:0], rx_byte};

  always_comb begin
    phase_next        = phase;
    sync_window_next  = sync_window;
    field_count_next  = field_count;
    type_accum_next   = type_accum;
    length_accum_next = length_accum;
    res_valid         = 1'b0;
    res.frame_type    = type_accum;
    res.frame_length  = length_accum;
    res.byte_offset   = field_count;
    res.payload_byte  = rx_byte;
    res.has_byte      = 1'b1;
    res.frame_end     = 1'b0;
    unique case (phase)
      PH_HUNT: begin
        sync_window_next = window_shift;
        if (window_shift == sync_pattern) begin
          phase_next       = PH_TYPE;
          field_count_next = '0;
        end
      end
      PH_TYPE: begin
        type_accum_next  = {type_accum[15-BYTE_BITS:0], rx_byte};
        field_count_next = count_inc;
        if (count_inc == 32'(TYPE_BYTES)) begin
          phase_next       = PH_LENGTH;
          field_count_next = '0;
        end
      end
      PH_LENGTH: begin
        length_accum_next = length_shift;
        field_count_next  = count_inc;
        if (count_inc == 32'(LENGTH_BYTES)) begin
          field_count_next = '0;
          if (length_shift == '0) begin
            // empty frame: one marker result, no byte
            phase_next       = PH_HUNT;
            res_valid        = 1'b1;
            res.frame_length = length_shift;
            res.byte_offset  = '0;
            res.payload_byte = '0;
            res.has_byte     = 1'b0;
            res.frame_end    = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        res_valid        = 1'b1;
        field_count_next = count_inc;
        if (count_inc == length_accum) begin
          res.frame_end    = 1'b1;
          phase_next       = PH_HUNT;
          field_count_next = '0;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
    if (!accept) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      sync_window  <= '0;
      field_count  <= '0;
      type_accum   <= '0;
      length_accum <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      sync_window  <= sync_window_next;
      field_count  <= field_count_next;
      type_accum   <= type_accum_next;
      length_accum <= length_accum_next;
    end
  end

endmodule

// ===== hw/rtl/stfp_checker.sv =====
// Port-level checker for the frame parser, bound to the top level.
`timescale 1ns / 1ps
module stfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] frame_type,
  input logic [31:0] frame_length,
  input logic [31:0] byte_offset,
  input logic [7:0]  payload_byte,
  input logic        has_byte,
  input logic        frame_end
);

  // a stalled request holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_type) &&
      $stable(frame_length) && $stable(byte_offset) &&
      $stable(payload_byte) && $stable(has_byte) && $stable(frame_end))
    else $error("stalled output request changed");

  // input stalls only with a full output register ahead of the skid stage
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  a_empty_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> frame_end && payload_byte == 8'd0 &&
      byte_offset == 32'd0 && frame_length == 32'd0)
    else $error("malformed empty-frame marker");

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_byte |-> byte_offset < frame_length)
    else $error("payload offset beyond frame length");

  a_last_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_byte |-> frame_end == (byte_offset == frame_length - 32'd1))
    else $error("frame end flag does not match last offset");

endmodule

bind sync_tlv_frame_parser_unit stfp_checker u_stfp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .frame_type   (frame_type),
  .frame_length (frame_length),
  .byte_offset  (byte_offset),
  .payload_byte (payload_byte),
  .has_byte     (has_byte),
  .frame_end    (frame_end)
);
